// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the requantizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/frq_pkg.sv =====
// ----------------------------------------------------------------------------
// frq_pkg
// shared widths, mode codes and pipeline control type of the requantizer
// ----------------------------------------------------------------------------
`default_nettype none

package frq_pkg;

    // field widths
    localparam int CODE_W = 64;
    localparam int TB_W   = 5;
    localparam int IB_W   = 6;
    localparam int MODE_W = 3;
    localparam int FB_W   = 5;
    localparam int SH_W   = 6;

    localparam logic [CODE_W-1:0] CODE_ONES = {CODE_W{1'b1}};
    localparam logic [CODE_W-1:0] CODE_MAX  = {1'b0, {(CODE_W-1){1'b1}}};
    localparam logic [CODE_W-1:0] CODE_MIN  = {1'b1, {(CODE_W-1){1'b0}}};

    // rounding modes, higher codes round half to even
    localparam logic [MODE_W-1:0] RM_TRUNC      = 3'd0;
    localparam logic [MODE_W-1:0] RM_HALF_AWAY  = 3'd1;
    localparam logic [MODE_W-1:0] RM_ZERO       = 3'd2;
    localparam logic [MODE_W-1:0] RM_FLOOR      = 3'd3;
    localparam logic [MODE_W-1:0] RM_CEIL       = 3'd4;

    // overflow modes, unlisted codes wrap
    localparam logic [MODE_W-1:0] WM_SAT        = 3'd0;
    localparam logic [MODE_W-1:0] WM_SAT_ZERO   = 3'd1;
    localparam logic [MODE_W-1:0] WM_WRAP       = 3'd2;
    localparam logic [MODE_W-1:0] WM_SM_WRAP    = 3'd3;
    localparam logic [MODE_W-1:0] WM_SYM_SAT    = 3'd4;

    // decoded format that travels down the pipeline with each word
    typedef struct packed {
        logic              coarse;  // coarse grid path
        logic              zero;    // coarse shift beyond the word, code is zero
        logic              up;      // scale up (left shift) instead of down
        logic              sg;      // signed range
        logic [MODE_W-1:0] rm;
        logic [MODE_W-1:0] wm;
        logic [TB_W-1:0]   et;      // effective width for wrapping
        logic [IB_W-1:0]   nbits;   // bits of the representable range
        logic [FB_W-1:0]   frac;
        logic [IB_W-1:0]   z;       // coarse grid exponent
        logic [SH_W-1:0]   sh;      // scaling shift amount
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/frq_in_if.sv =====
// ----------------------------------------------------------------------------
// frq_in_if
// input channel: value and target format, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface frq_in_if import frq_pkg::*; #(
    parameter int VALUE_WIDTH = 48
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [TB_W-1:0]               word_width;
    logic [IB_W-1:0]               int_width;
    logic                          signed_format;
    logic [MODE_W-1:0]             round_mode;
    logic [MODE_W-1:0]             wrap_mode;
    logic [TB_W-1:0]               sat_width;

    modport source (
        output valid, value, word_width, int_width, signed_format,
               round_mode, wrap_mode, sat_width,
        input  ready
    );

    modport sink (
        input  valid, value, word_width, int_width, signed_format,
               round_mode, wrap_mode, sat_width,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/frq_out_if.sv =====
// ----------------------------------------------------------------------------
// frq_out_if
// output channel: quantized code and its fraction-bit count
// ----------------------------------------------------------------------------
`default_nettype none

interface frq_out_if import frq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [CODE_W-1:0] code;
    logic [FB_W-1:0]          frac_bits;

    modport source (
        output valid, code, frac_bits,
        input  ready
    );

    modport sink (
        input  valid, code, frac_bits,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/fixed_point_requantizer.sv =====
// ----------------------------------------------------------------------------
// fixed_point_requantizer
// requantizes a wide signed fixed-point value into a target fixed-point format
//
//   channel  dir  payload                                         handshake
//   i_in     in   value, word_width, int_width, signed_format,    valid/ready
//                 round_mode, wrap_mode, sat_width
//   o_out    out  code, frac_bits                                 valid/ready
//
// five register stages: decode, scaling shift, rounding add, range compare,
// final select; one word per cycle sustained while the output is not stalled.
// every stage holds its own valid bit and advances when the next one is free,
// so bubbles are squeezed out and a stall holds every word in place.
// reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fixed_point_requantizer import frq_pkg::*; #(
    parameter int IN_FRAC     = 16,
    parameter int VALUE_WIDTH = 48,
    parameter int MAX_TOTAL   = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    frq_in_if.sink     i_in,
    frq_out_if.source  o_out
);

    // pipeline valid bits and advance enables
    logic [5:1] r_vld;
    logic [5:1] adv;

    // stage registers
    logic [CODE_W-1:0] r1_v,   n1_v;
    t_ctl              r1_ctl, n1_ctl;

    logic [CODE_W-1:0] r2_q,   n2_q;
    logic              r2_rbit, n2_rbit;
    logic              r2_sticky, n2_sticky;
    logic              r2_ovf, n2_ovf;
    logic              r2_neg;
    t_ctl              r2_ctl;

    logic [CODE_W-1:0] r3_raw, n3_raw;
    logic [CODE_W-1:0] r3_mx,  n3_mx;
    logic [CODE_W-1:0] r3_mn,  n3_mn;
    logic              r3_ovf;
    logic              r3_neg;
    t_ctl              r3_ctl;

    logic [CODE_W-1:0] r4_sel, n4_sel;
    logic [CODE_W-1:0] r4_mag, n4_mag;
    logic              r4_cneg, n4_cneg;
    t_ctl              r4_ctl;

    logic [CODE_W-1:0] r5_code, n5_code;
    logic [FB_W-1:0]   r5_frac;

    // handshake: a stage moves when empty or when its successor moves
    always_comb begin
        adv[5] = !r_vld[5] || o_out.ready;
        adv[4] = !r_vld[4] || adv[5];
        adv[3] = !r_vld[3] || adv[4];
        adv[2] = !r_vld[2] || adv[3];
        adv[1] = !r_vld[1] || adv[2];
    end

    assign i_in.ready      = adv[1];
    assign o_out.valid     = r_vld[5];
    assign o_out.code      = r5_code;
    assign o_out.frac_bits = r5_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) r_vld[1] <= i_in.valid;
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
            if (adv[4]) r_vld[4] <= r_vld[3];
            if (adv[5]) r_vld[5] <= r_vld[4];
        end
    end

    // stage 1: format decode
    logic [TB_W-1:0] w, sw, et, f;
    logic [IB_W-1:0] ib, ei, f6, z;
    logic [IB_W:0]   cs;

    always_comb begin
        n1_v = CODE_W'($signed(i_in.value[VALUE_WIDTH-1:0]));
        ib   = i_in.int_width;
        w    = ({1'b0, i_in.word_width} > IB_W'(MAX_TOTAL)) ? TB_W'(MAX_TOTAL)
                                                            : i_in.word_width;
        sw   = ({1'b0, i_in.sat_width} > IB_W'(MAX_TOTAL)) ? TB_W'(MAX_TOTAL)
                                                           : i_in.sat_width;
        et   = (sw != '0 && sw < w) ? sw : w;
        ei   = (ib < {1'b0, et}) ? ib : {1'b0, et};
        f    = et - ei[TB_W-1:0];
        z    = ib - {1'b0, w};
        cs   = {1'b0, z} + (IB_W+1)'(IN_FRAC);

        n1_ctl        = '0;
        n1_ctl.rm     = i_in.round_mode;
        n1_ctl.z      = z;
        n1_ctl.et     = et;
        if (ib > {1'b0, w}) begin
            // coarse grid: round half up, clamp symmetric to w bits, shift by z
            n1_ctl.coarse = 1'b1;
            n1_ctl.zero   = cs[IB_W];
            n1_ctl.sg     = 1'b1;
            n1_ctl.wm     = WM_SYM_SAT;
            n1_ctl.nbits  = {1'b0, w};
            n1_ctl.frac   = '0;
            n1_ctl.up     = 1'b0;
            n1_ctl.sh     = cs[IB_W] ? {SH_W{1'b1}} : cs[SH_W-1:0];
        end else begin
            n1_ctl.sg    = i_in.signed_format;
            n1_ctl.wm    = i_in.wrap_mode;
            // signed with no integer bits keeps all w bits as fraction
            if (ib == '0 && i_in.signed_format) begin
                f            = w;
                n1_ctl.nbits = {w, 1'b1};
            end else begin
                n1_ctl.nbits = {1'b0, et};
            end
            n1_ctl.frac = f;
            f6          = {1'b0, f};
            if (f6 >= IB_W'(IN_FRAC)) begin
                n1_ctl.up = 1'b1;
                n1_ctl.sh = f6 - IB_W'(IN_FRAC);
            end else begin
                n1_ctl.up = 1'b0;
                n1_ctl.sh = IB_W'(IN_FRAC) - f6;
            end
        end
        f6 = {1'b0, f};
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_v   <= n1_v;
            r1_ctl <= n1_ctl;
        end
    end

    // stage 2: scaling shift, round and sticky bits, overflow on scale up
    logic [SH_W-1:0]   rpos;
    logic [CODE_W-1:0] top;

    always_comb begin
        rpos      = r1_ctl.sh - SH_W'(1);
        n2_rbit   = r1_v[rpos];
        n2_sticky = |(r1_v & ~(CODE_ONES << rpos));
        top       = CODE_W'($signed(r1_v) >>> (SH_W'(CODE_W-1) - r1_ctl.sh));
        if (r1_ctl.up) begin
            n2_q   = r1_v << r1_ctl.sh;
            n2_ovf = !((&top) || !(|top));
        end else begin
            n2_q   = CODE_W'($signed(r1_v) >>> r1_ctl.sh);
            n2_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_q      <= n2_q;
            r2_rbit   <= n2_rbit;
            r2_sticky <= n2_sticky;
            r2_ovf    <= n2_ovf;
            r2_neg    <= r1_v[CODE_W-1];
            r2_ctl    <= r1_ctl;
        end
    end

    // stage 3: rounding increment and range bounds
    logic inc;

    always_comb begin
        if (r2_ctl.up) begin
            inc = 1'b0;
        end else if (r2_ctl.coarse) begin
            inc = r2_rbit;
        end else begin
            case (r2_ctl.rm)
                RM_TRUNC, RM_ZERO: inc = r2_neg && (r2_rbit || r2_sticky);
                RM_HALF_AWAY:      inc = r2_neg ? (r2_rbit && r2_sticky) : r2_rbit;
                RM_FLOOR:          inc = 1'b0;
                RM_CEIL:           inc = r2_rbit || r2_sticky;
                default:           inc = r2_rbit && (r2_sticky || r2_q[0]);
            endcase
        end
        n3_raw = r2_q + CODE_W'(inc);

        if (r2_ctl.sg) begin
            if (r2_ctl.nbits == '0) begin
                n3_mx = '0;
                n3_mn = '0;
            end else begin
                n3_mx = ~(CODE_ONES << (r2_ctl.nbits - IB_W'(1)));
                n3_mn = ~n3_mx;
            end
        end else begin
            n3_mx = ~(CODE_ONES << r2_ctl.nbits);
            n3_mn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_raw <= n3_raw;
            r3_mx  <= n3_mx;
            r3_mn  <= n3_mn;
            r3_ovf <= r2_ovf;
            r3_neg <= r2_neg;
            r3_ctl <= r2_ctl;
        end
    end

    // mask of the bits below the sign bit of an et-bit word
    function automatic logic [CODE_W-1:0] mask_et_half(input logic [TB_W-1:0] n);
        logic [CODE_W-1:0] m;
        m = ~(CODE_ONES << (n - TB_W'(1)));
        return m;
    endfunction

    // stage 4: range compares, clamp and wrap candidates, magnitude
    logic [CODE_W-1:0] c, nmx, mask_et, mask_em1, mag_full, wr;
    logic              gt_mx, lt_mn, lt_nmx;

    always_comb begin
        c        = r3_ovf ? (r3_neg ? CODE_MIN : CODE_MAX) : r3_raw;
        nmx      = (r3_mx == '0) ? '0 : {r3_mn[CODE_W-1:1], 1'b1};
        gt_mx    = $signed(c) > $signed(r3_mx);
        lt_mn    = $signed(c) < $signed(r3_mn);
        lt_nmx   = $signed(c) < $signed(nmx);
        n4_cneg  = c[CODE_W-1];

        mask_et  = ~(CODE_ONES << r3_ctl.et);
        mask_em1 = (r3_ctl.et == '0) ? '0 : ~(CODE_ONES << (r3_ctl.et - TB_W'(1)));
        mag_full = n4_cneg ? (CODE_W'(0) - r3_raw) : r3_raw;
        n4_mag   = mag_full & mask_em1;

        // wrap into et bits, sign extended for signed formats
        wr = r3_raw & mask_et;
        if (r3_ctl.sg && r3_ctl.et != '0 && (|(wr & ~mask_et_half(r3_ctl.et)))) begin
            wr = wr | ~mask_et;
        end

        case (r3_ctl.wm)
            WM_SAT:      n4_sel = gt_mx ? r3_mx : (lt_mn ? r3_mn : c);
            WM_SAT_ZERO: n4_sel = (gt_mx || lt_mn) ? '0 : c;
            WM_SYM_SAT: begin
                if (gt_mx)                   n4_sel = r3_mx;
                else if (r3_ctl.sg && lt_nmx) n4_sel = nmx;
                else                         n4_sel = c;
            end
            default:     n4_sel = wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_sel  <= n4_sel;
            r4_mag  <= n4_mag;
            r4_cneg <= n4_cneg;
            r4_ctl  <= r3_ctl;
        end
    end

    // stage 5: sign-magnitude rebuild, coarse grid scaling, output register
    always_comb begin
        if (r4_ctl.zero) begin
            n5_code = '0;
        end else if (r4_ctl.coarse) begin
            n5_code = r4_sel << r4_ctl.z;
        end else if (r4_ctl.wm == WM_SM_WRAP && r4_ctl.sg) begin
            n5_code = r4_cneg ? (CODE_W'(0) - r4_mag) : r4_mag;
        end else begin
            n5_code = r4_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_code <= n5_code;
            r5_frac <= r4_ctl.frac;
        end
    end

    // checks
    `ASSERT_PROP(a_frac_range, i_clk, i_rst_n,
        o_out.valid |-> (int'(o_out.frac_bits) <= MAX_TOTAL),
        "frac_bits beyond the widest target format")
    `ASSERT_PROP(a_stall_holds, i_clk, i_rst_n,
        r_vld[5] && !o_out.ready && r_vld[4] |=> r_vld[4] && r_vld[5],
        "word lost while the output is stalled")
    `ASSERT_PROP(a_coarse_zero, i_clk, i_rst_n,
        r_vld[4] && r4_ctl.zero && adv[5] |=> o_out.code == '0,
        "coarse grid beyond the word did not give zero")

endmodule

`default_nettype wire

// ===== tb/requant_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// requant_checker
// watches both channels of the requantizer, works out the code and fraction
// count of every accepted input word in exact integer arithmetic, and
// compares each output word against the oldest one still pending
// ----------------------------------------------------------------------------
module requant_checker import frq_pkg::*; #(
    parameter int IN_FRAC     = 16,
    parameter int VALUE_WIDTH = 48,
    parameter int MAX_TOTAL   = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    frq_in_if    i_in,
    frq_out_if   i_out,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [FB_W-1:0]   frac;
    } t_quant;

    localparam longint S64_MAX = $signed(CODE_MAX);
    localparam longint S64_MIN = $signed(CODE_MIN);

    t_quant pending_codes [$];
    t_quant oldest;
    int     pending_words = 0;
    int     fail_total    = 0;

    assign o_pending    = pending_words;
    assign o_fail_count = fail_total;

    function automatic logic [63:0] ones_below(int k);
        return (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
    endfunction

    // requantize one value into its target format
    function automatic t_quant requantize(
        logic [63:0]       v,
        logic [TB_W-1:0]   tb,
        logic [IB_W-1:0]   ib_in,
        logic              sg,
        logic [MODE_W-1:0] rm,
        logic [MODE_W-1:0] wm,
        logic [TB_W-1:0]   sw_in
    );
        int          w, ib, sw, et, ei, f, z, s, d, p;
        logic        neg;
        logic [63:0] raw, q, rem, half, res, mag;
        longint      c, n, lim, mn, mx, nmn;
        t_quant      r;
        neg = v[63];
        w   = (tb > MAX_TOTAL) ? MAX_TOTAL : int'(tb);
        sw  = (sw_in > MAX_TOTAL) ? MAX_TOTAL : int'(sw_in);
        ib  = ib_in;

        // coarse grid: nearest multiple of 2^z, ties upward
        if (w < ib) begin
            z = ib - w;
            s = z + IN_FRAC;
            r.frac = '0;
            if (w <= 1 || s >= 64) begin
                r.code = '0;
            end else begin
                n = $signed(v) >>> s;
                if (v[s-1]) n = n + 1;
                lim = (longint'(1) << (w - 1)) - 1;
                if (n > lim) n = lim;
                if (n < -lim) n = -lim;
                r.code = 64'(n) << z;
            end
            return r;
        end

        et = (sw > 0 && sw < w) ? sw : w;
        ei = (ib < et) ? ib : et;
        f  = et - ei;
        // signed with no integer bits keeps the whole width as fraction
        if (ib == 0 && sg) begin
            f  = w;
            ei = w + 1;
        end

        // scale to units of 2^-f and round
        if (f >= IN_FRAC) begin
            d = f - IN_FRAC;
            if (d > 63) d = 63;
            raw = v << d;
            if ((64'($signed(raw) >>> d) == v) && (raw[63] == neg)) c = $signed(raw);
            else c = neg ? S64_MIN : S64_MAX;
        end else begin
            s = IN_FRAC - f;
            if (s > 63) s = 63;
            q    = $signed(v) >>> s;
            rem  = v & ones_below(s);
            half = 64'd1 << (s - 1);
            case (rm)
                RM_TRUNC, RM_ZERO: begin
                    if (neg && rem != 0) q = q + 1;
                end
                RM_HALF_AWAY: begin
                    if (neg ? (rem > half) : (rem >= half)) q = q + 1;
                end
                RM_FLOOR: ;
                RM_CEIL: begin
                    if (rem != 0) q = q + 1;
                end
                default: begin
                    if (rem > half || (rem == half && q[0])) q = q + 1;
                end
            endcase
            raw = q;
            c   = $signed(q);
        end

        // representable range of the target format
        if (sg) begin
            if (ei + f == 0) begin
                mn = 0;
                mx = 0;
            end else begin
                p = ei + f - 1;
                if (p >= 63) begin
                    mn = S64_MIN;
                    mx = S64_MAX;
                end else begin
                    mn = -(longint'(1) << p);
                    mx = (longint'(1) << p) - 1;
                end
            end
        end else begin
            p  = ei + f;
            mn = 0;
            mx = (p >= 63) ? S64_MAX : ((longint'(1) << p) - 1);
        end

        // overflow handling
        case (wm)
            WM_SAT: begin
                if (c > mx) c = mx;
                if (c < mn) c = mn;
                res = c;
            end
            WM_SAT_ZERO: begin
                res = (c > mx || c < mn) ? 64'd0 : 64'(c);
            end
            WM_SM_WRAP: begin
                if (sg) begin
                    mag = (c < 0) ? (64'd0 - raw) : raw;
                    mag = mag & ((et >= 1) ? ones_below(et - 1) : 64'd0);
                    res = (c < 0) ? (64'd0 - mag) : mag;
                end else begin
                    res = raw & ones_below(et);
                end
            end
            WM_SYM_SAT: begin
                if (sg) begin
                    nmn = (mn == S64_MIN) ? S64_MAX : -mn;
                    lim = (mx < nmn) ? mx : nmn;
                    if (c > lim) c = lim;
                    if (c < -lim) c = -lim;
                end else if (c > mx) begin
                    c = mx;
                end
                res = c;
            end
            default: begin
                res = raw & ones_below(et);
                if (sg && et >= 1 && res[et-1]) res = res | ~ones_below(et);
            end
        endcase

        r.code = res;
        r.frac = f[FB_W-1:0];
        return r;
    endfunction

    // compare output words, then record the word taken in
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (pending_codes.size() == 0) begin
                    $error("unexpected word: code %0d, frac_bits %0d",
                           i_out.code, i_out.frac_bits);
                    fail_total++;
                end else begin
                    oldest = pending_codes.pop_front();
                    if (i_out.code !== oldest.code) begin
                        $error("code: expected %0d, actual %0d",
                               $signed(oldest.code), i_out.code);
                        fail_total++;
                    end
                    if (i_out.frac_bits !== oldest.frac) begin
                        $error("frac_bits: expected %0d, actual %0d",
                               oldest.frac, i_out.frac_bits);
                        fail_total++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                pending_codes.insert(pending_codes.size(), requantize(
                    64'(i_in.value), i_in.word_width, i_in.int_width,
                    i_in.signed_format, i_in.round_mode, i_in.wrap_mode,
                    i_in.sat_width));
            end
        end
        pending_words = pending_codes.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives the requantizer with a directed set of corner words and then a long
// run of random formats and values, with random gaps on the input side and
// random stalls on the output side; the checker beside the block predicts
// and compares, and this module reports the verdict
// ----------------------------------------------------------------------------
module testbench import frq_pkg::*;;

    localparam int IN_FRAC      = 16;
    localparam int VALUE_WIDTH  = 48;
    localparam int MAX_TOTAL    = 24;
    localparam int RANDOM_WORDS = 1850;
    localparam int CALM_WORDS   = 300;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending_words;
    int   fail_count;
    bit   calm     = 1'b0;
    int   gap_odds = 4;

    frq_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
    frq_out_if out_ch ();

    fixed_point_requantizer #(
        .IN_FRAC    (IN_FRAC),
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_TOTAL  (MAX_TOTAL)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    requant_checker #(
        .IN_FRAC    (IN_FRAC),
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_TOTAL  (MAX_TOTAL)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_pending   (pending_words),
        .o_fail_count(fail_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // present one word, after an optional gap, and hold it until taken
    task automatic send(
        input logic [VALUE_WIDTH-1:0] v,
        input int                     tb,
        input int                     ib,
        input logic                   sg,
        input logic [MODE_W-1:0]      rm,
        input logic [MODE_W-1:0]      wm,
        input int                     sw
    );
        if (!calm && gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.value         <= v;
        in_ch.word_width    <= TB_W'(tb);
        in_ch.int_width     <= IB_W'(ib);
        in_ch.signed_format <= sg;
        in_ch.round_mode    <= rm;
        in_ch.wrap_mode     <= wm;
        in_ch.sat_width     <= TB_W'(sw);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // output side stalls in bursts
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [63:0]            r64;
        logic [VALUE_WIDTH-1:0] v;
        int                     k, tb, ib, sw, lsb;
        in_ch.valid         <= 1'b0;
        in_ch.value         <= '0;
        in_ch.word_width    <= '0;
        in_ch.int_width     <= '0;
        in_ch.signed_format <= 1'b0;
        in_ch.round_mode    <= RM_TRUNC;
        in_ch.wrap_mode     <= WM_SAT;
        in_ch.sat_width     <= '0;
        i_rst_n             <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // value extremes into an 8.16 signed format
        send(VAL_MAX, 24, 8, 1'b1, RM_HALF_AWAY, WM_SAT, 0);
        send(VAL_MIN, 24, 8, 1'b1, RM_HALF_AWAY, WM_SAT_ZERO, 0);
        // every rounding mode on a +-2.5 tie
        for (int m = 0; m < 8; m++)
            send(VALUE_WIDTH'(m[0] ? (5 << 15) : -(5 << 15)), 8, 8, 1'b1,
                 MODE_W'(m), WM_SAT, 0);
        // every overflow mode on +-300.75 into a 4.4 signed format
        for (int m = 0; m < 8; m++)
            send(VALUE_WIDTH'(m[0] ? -((300 << 16) + (3 << 14))
                                   : ((300 << 16) + (3 << 14))),
                 8, 4, 1'b1, RM_TRUNC, MODE_W'(m), 0);
        // signed with no integer bits
        send(VALUE_WIDTH'(19661), 8, 0, 1'b1, RM_HALF_AWAY, WM_SAT, 0);
        // unsigned symmetric saturate lets negatives through
        send(VALUE_WIDTH'(-(5 << 16)), 8, 4, 1'b0, RM_FLOOR, WM_SYM_SAT, 0);
        // zero effective width
        send(VALUE_WIDTH'((7 << 16) + 5), 0, 0, 1'b0, RM_CEIL, WM_WRAP, 0);
        // coarse grid, a value that rounds upward and then clamps
        send(VALUE_WIDTH'((1000 << 16) + (1 << 15)), 4, 10, 1'b1, RM_TRUNC, WM_SAT, 0);
        // coarse grid with a single-bit word
        send(VALUE_WIDTH'(100 << 16), 1, 5, 1'b1, RM_TRUNC, WM_SAT, 0);
        // coarse grid with a huge exponent
        send(VAL_MAX, 20, 63, 1'b1, RM_TRUNC, WM_WRAP, 0);
        // widths above the maximum are clamped, narrow saturation width
        send(VAL_MIN + 48'h1234_5678, 31, 3, 1'b0, RM_CEIL, WM_SM_WRAP, 31);
        send(VALUE_WIDTH'(-(37 << 14)), 16, 2, 1'b1, RM_FLOOR, WM_WRAP, 6);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
            if (i % 50 == 0) gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            // let the pipe run dry once with the sender held back
            if (i == RANDOM_WORDS / 2) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_words != 0) @(posedge i_clk);
            end

            // target format: mostly regular widths, some of the whole field range
            tb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0:       ib = $urandom_range(0, 63);
                1:       ib = 0;
                default: ib = $urandom_range(0, tb + 4);
            endcase
            case ($urandom_range(0, 3))
                0, 1:    sw = 0;
                2:       sw = $urandom_range(0, 31);
                default: sw = $urandom_range(1, (tb > 0) ? tb : 1);
            endcase

            // value: full range, sized near the format edge, rounding ties, extremes
            r64 = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0: v = r64[VALUE_WIDTH-1:0];
                1: begin
                    k = $urandom_range(1, VALUE_WIDTH);
                    v = VALUE_WIDTH'($signed(r64) >>> (64 - k));
                end
                2: begin
                    k = tb + IN_FRAC + $urandom_range(0, 2) - 1;
                    if (k > VALUE_WIDTH) k = VALUE_WIDTH;
                    if (k < 1) k = 1;
                    v = VALUE_WIDTH'($signed(r64) >>> (64 - k));
                end
                3: begin
                    k   = $urandom_range(17, 40);
                    lsb = $urandom_range(0, 15);
                    v   = VALUE_WIDTH'($signed(r64) >>> (64 - k));
                    v   = (v & ~((VALUE_WIDTH'(1) << (lsb + 1)) - VALUE_WIDTH'(1)))
                          | (VALUE_WIDTH'(1) << lsb);
                    v   = v + VALUE_WIDTH'($urandom_range(0, 2)) - VALUE_WIDTH'(1);
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       v = VAL_MAX;
                        1:       v = VAL_MIN;
                        2:       v = '0;
                        3:       v = '1;
                        4:       v = VALUE_WIDTH'(1);
                        default: v = VAL_MIN + VALUE_WIDTH'(1);
                    endcase
                end
            endcase

            send(v, tb, ib, 1'($urandom_range(0, 1)),
                 MODE_W'($urandom_range(0, 7)), MODE_W'($urandom_range(0, 7)), sw);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_words == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
